FILE: rtl/core/qvr_pkg.sv
// Shared constants and types for the quaternion vector rotation unit.
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

	// Quaternion register width and the width of one rotation-matrix term.
	// A matrix term is at most twice a difference of two 32-bit products.
	localparam int QUAT_W = 16;
	localparam int PRODQ_W = 2 * QUAT_W;
	localparam int MAT_W = 2 * QUAT_W + 3;

	// Matrix terms are split into an unsigned low part and a signed high
	// part so that each multiplier's term operand stays near 18 bits wide.
	localparam int MAT_SPLIT = 18;

	// Default sizes handed to the top level.
	localparam int VEC_BITS_DEF = 24;
	localparam int QUAT_FRAC_BITS_DEF = 14;

	// Number of vector components, and so of lanes.
	localparam int NUM_AXES = 3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 2'd3;

	// One term of the rotation matrix.
	typedef logic signed [MAT_W-1:0] mat_term_t;

	// Stage load enables handed from the pipeline control to each lane.
	typedef struct packed {
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} lane_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/qvr_matrix.sv
// Quaternion registers and the registered rotation matrix built from them.
`timescale 1ns / 1ps
`default_nettype none

module qvr_matrix #(
	parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [qvr_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire logic [qvr_pkg::QUAT_W-1:0]       wr_data,
	output qvr_pkg::mat_term_t                    mat [qvr_pkg::NUM_AXES][qvr_pkg::NUM_AXES]
);

	localparam int QW = qvr_pkg::QUAT_W;
	localparam int PW = qvr_pkg::PRODQ_W;
	localparam int MW = qvr_pkg::MAT_W;
	localparam logic signed [QW-1:0] W_RESET = QW'(64'd1 << QUAT_FRAC_BITS);

	logic signed [QW-1:0] w_q, x_q, y_q, z_q;
	logic signed [PW-1:0] ww_q, wx_q, wy_q, wz_q, xx_q, xy_q, xz_q, yy_q, yz_q, zz_q;
	logic signed [MW-1:0] e_ww, e_wx, e_wy, e_wz, e_xx, e_xy, e_xz, e_yy, e_yz, e_zz;
	qvr_pkg::mat_term_t mat_d [qvr_pkg::NUM_AXES][qvr_pkg::NUM_AXES];
	qvr_pkg::mat_term_t mat_q [qvr_pkg::NUM_AXES][qvr_pkg::NUM_AXES];

	// Quaternion registers, written through the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= W_RESET;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				qvr_pkg::REG_QUAT_W: w_q <= wr_data;
				qvr_pkg::REG_QUAT_X: x_q <= wr_data;
				qvr_pkg::REG_QUAT_Y: y_q <= wr_data;
				qvr_pkg::REG_QUAT_Z: z_q <= wr_data;
				default: ;
			endcase
		end
	end

	// The ten pairwise products, registered.
	always_ff @(posedge clk) begin
		ww_q <= w_q * w_q;
		wx_q <= w_q * x_q;
		wy_q <= w_q * y_q;
		wz_q <= w_q * z_q;
		xx_q <= x_q * x_q;
		xy_q <= x_q * y_q;
		xz_q <= x_q * z_q;
		yy_q <= y_q * y_q;
		yz_q <= y_q * z_q;
		zz_q <= z_q * z_q;
	end

	// Matrix terms; the off-diagonal sums are doubled.
	always_comb begin
		e_ww = MW'(ww_q);
		e_wx = MW'(wx_q);
		e_wy = MW'(wy_q);
		e_wz = MW'(wz_q);
		e_xx = MW'(xx_q);
		e_xy = MW'(xy_q);
		e_xz = MW'(xz_q);
		e_yy = MW'(yy_q);
		e_yz = MW'(yz_q);
		e_zz = MW'(zz_q);
		mat_d[0][0] = e_ww + e_xx - e_yy - e_zz;
		mat_d[0][1] = (e_xy - e_wz) <<< 1;
		mat_d[0][2] = (e_wy + e_xz) <<< 1;
		mat_d[1][0] = (e_wz + e_xy) <<< 1;
		mat_d[1][1] = e_ww - e_xx + e_yy - e_zz;
		mat_d[1][2] = (e_yz - e_wx) <<< 1;
		mat_d[2][0] = (e_xz - e_wy) <<< 1;
		mat_d[2][1] = (e_wx + e_yz) <<< 1;
		mat_d[2][2] = e_ww - e_xx - e_yy + e_zz;
	end

	// Matrix register, refreshed every cycle from the product register.
	always_ff @(posedge clk) begin
		mat_q <= mat_d;
	end

	assign mat = mat_q;

endmodule

`default_nettype wire

FILE: rtl/core/qvr_lane.sv
// One lane: a matrix row times the vector, then rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module qvr_lane #(
	parameter int VEC_BITS       = qvr_pkg::VEC_BITS_DEF,
	parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire qvr_pkg::lane_ctl_t    ctl,
	input  wire qvr_pkg::mat_term_t    row [qvr_pkg::NUM_AXES],
	input  wire logic signed [VEC_BITS-1:0] vec [qvr_pkg::NUM_AXES],
	output logic signed [VEC_BITS-1:0] rot,
	output logic                       clip
);

	localparam int NA     = qvr_pkg::NUM_AXES;
	localparam int MW     = qvr_pkg::MAT_W;
	localparam int ML     = qvr_pkg::MAT_SPLIT;
	localparam int MH     = MW - ML;
	localparam int LO_W   = ML + 1 + VEC_BITS;
	localparam int HI_W   = MH + VEC_BITS;
	localparam int PROD_W = MW + VEC_BITS;
	localparam int ACC_W  = PROD_W + 2;
	localparam int SHIFT  = 2 * QUAT_FRAC_BITS;
	localparam int RND_W  = ((ACC_W > SHIFT) ? ACC_W : SHIFT + 1) + 1;
	localparam logic signed [RND_W-1:0] BIAS = {{(RND_W-1){1'b0}}, 1'b1} << (SHIFT - 1);
	localparam logic signed [VEC_BITS-1:0] MAXV = {1'b0, {(VEC_BITS-1){1'b1}}};
	localparam logic signed [VEC_BITS-1:0] MINV = {1'b1, {(VEC_BITS-1){1'b0}}};

	logic signed [LO_W-1:0]   lo_s3 [NA];
	logic signed [HI_W-1:0]   hi_s3 [NA];
	logic signed [PROD_W-1:0] term_s4 [NA];
	logic signed [ACC_W-1:0]  acc_s5;
	logic signed [RND_W-1:0]  rnd;
	logic signed [RND_W-1:0]  rnd_sh;
	logic [RND_W-VEC_BITS:0]  top_bits;
	logic                     fits;

	// Partial products: low part of each term is unsigned, high part signed.
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			for (int i = 0; i < NA; i++) begin
				lo_s3[i] <= $signed({1'b0, row[i][ML-1:0]}) * vec[i];
				hi_s3[i] <= $signed(row[i][MW-1:ML]) * vec[i];
			end
		end
	end

	// Whole products from the two halves.
	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			for (int i = 0; i < NA; i++) begin
				term_s4[i] <= (PROD_W'(hi_s3[i]) <<< ML) + PROD_W'(lo_s3[i]);
			end
		end
	end

	// Dot product of the row with the vector.
	always_ff @(posedge clk) begin
		if (ctl.en_s5) begin
			acc_s5 <= ACC_W'(term_s4[0]) + ACC_W'(term_s4[1]) + ACC_W'(term_s4[2]);
		end
	end

	// Round half up, drop the fraction bits and clamp to the output range.
	always_comb begin
		rnd      = RND_W'(acc_s5) + BIAS;
		rnd_sh   = rnd >>> SHIFT;
		top_bits = rnd_sh[RND_W-1:VEC_BITS-1];
		fits     = (&top_bits) | (~|top_bits);
		clip     = ~fits;
		if (fits) begin
			rot = rnd_sh[VEC_BITS-1:0];
		end else if (rnd[RND_W-1]) begin
			rot = MINV;
		end else begin
			rot = MAXV;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/quaternion_vector_rotate_unit.sv
// Top level of the quaternion vector rotation unit: pipeline control and lanes.
//
// Usage: software writes the quaternion (w, x, y, z, signed Q2.14) through the
// configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data); cfg_ready
// is always high. Writes take effect for transactions accepted afterwards.
// Vectors arrive on the input channel (in_valid, in_stall, vec_x/y/z) and the
// rotated, rounded and saturated vector leaves on the output channel
// (out_valid, out_stall, rot_x/y/z, clipped).
// One transaction per cycle is sustained while the receiver does not stall.
// After the accepting edge a transaction passes the second vector stage, the
// three lane stages (split partial products, whole products, sum) and the
// output register, which drives out_valid. The two vector stages let a
// quaternion write reach the two-stage matrix register first.
// Reset clears all stage valids and loads the identity quaternion.
// When the receiver stalls, the output register holds its transaction and
// earlier stages keep filling their empty slots; in_stall rises only once
// every stage holds a transaction.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_vector_rotate_unit #(
	parameter int VEC_BITS       = qvr_pkg::VEC_BITS_DEF,
	parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [qvr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [qvr_pkg::QUAT_W-1:0]        cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [VEC_BITS-1:0]        vec_x,
	input  wire logic signed [VEC_BITS-1:0]        vec_y,
	input  wire logic signed [VEC_BITS-1:0]        vec_z,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [VEC_BITS-1:0]             rot_x,
	output logic signed [VEC_BITS-1:0]             rot_y,
	output logic signed [VEC_BITS-1:0]             rot_z,
	output logic                                   clipped
);

	localparam int NA = qvr_pkg::NUM_AXES;

	qvr_pkg::mat_term_t        mat [NA][NA];
	qvr_pkg::lane_ctl_t        lane_ctl;
	logic signed [VEC_BITS-1:0] vec_s1 [NA];
	logic signed [VEC_BITS-1:0] vec_s2 [NA];
	logic signed [VEC_BITS-1:0] rot_lane [NA];
	logic [NA-1:0]              clip_lane;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic take1, take2, take3, take4, take5, take6;
	logic signed [VEC_BITS-1:0] rot_x_q, rot_y_q, rot_z_q;
	logic                       clipped_q;

	// Configuration port never back-pressures.
	assign cfg_ready = 1'b1;

	qvr_matrix #(
		.QUAT_FRAC_BITS(QUAT_FRAC_BITS)
	) u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.mat     (mat)
	);

	// A stage loads when it is empty or its contents move on this cycle.
	always_comb begin
		take6 = !out_valid_q || !out_stall;
		take5 = !v_s5 || take6;
		take4 = !v_s4 || take5;
		take3 = !v_s3 || take4;
		take2 = !v_s2 || take3;
		take1 = !v_s1 || take2;
		in_stall = !take1;
		lane_ctl.en_s3 = take3;
		lane_ctl.en_s4 = take4;
		lane_ctl.en_s5 = take5;
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take1) v_s1 <= in_valid;
			if (take2) v_s2 <= v_s1;
			if (take3) v_s3 <= v_s2;
			if (take4) v_s4 <= v_s3;
			if (take5) v_s5 <= v_s4;
			if (take6) out_valid_q <= v_s5;
		end
	end

	// Vector stages ahead of the lanes.
	always_ff @(posedge clk) begin
		if (take1) begin
			vec_s1[0] <= vec_x;
			vec_s1[1] <= vec_y;
			vec_s1[2] <= vec_z;
		end
		if (take2) begin
			vec_s2 <= vec_s1;
		end
	end

	// One lane per output component, each working on one matrix row.
	for (genvar g = 0; g < NA; g++) begin : g_lane
		qvr_lane #(
			.VEC_BITS      (VEC_BITS),
			.QUAT_FRAC_BITS(QUAT_FRAC_BITS)
		) u_lane (
			.clk (clk),
			.ctl (lane_ctl),
			.row (mat[g]),
			.vec (vec_s2),
			.rot (rot_lane[g]),
			.clip(clip_lane[g])
		);
	end

	// Merge stage: output register with the combined saturation flag.
	always_ff @(posedge clk) begin
		if (take6) begin
			rot_x_q   <= rot_lane[0];
			rot_y_q   <= rot_lane[1];
			rot_z_q   <= rot_lane[2];
			clipped_q <= |clip_lane;
		end
	end

	assign out_valid = out_valid_q;
	assign rot_x     = rot_x_q;
	assign rot_y     = rot_y_q;
	assign rot_z     = rot_z_q;
	assign clipped   = clipped_q;

	// An accepted transaction always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted transaction did not enter the first stage");

	// The input only stalls once every stage is full and the output is held.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_valid && out_stall)
		else $error("input stalled while the pipeline had room");

	// A finished sum moves into a free output register.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && (!out_valid || !out_stall) |=> out_valid)
		else $error("finished transaction was lost before the output register");

	// Output valid only rises behind a transaction in the last lane stage.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s5))
		else $error("output transaction appeared without a source");

endmodule

`default_nettype wire

FILE: test/tb_quaternion_vector_rotate_unit.sv
// Self-checking testbench for the quaternion vector rotation unit.
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate_unit;
	import qvr_pkg::*;

	localparam int VB = VEC_BITS_DEF;
	localparam int QF = QUAT_FRAC_BITS_DEF;
	localparam int NUM_QUAT_REGS = 4;
	localparam int RESET_CYCLES = 6;
	localparam int MAX_GAP = 13;
	localparam int IDLE_PAD = 10;
	localparam int RAND_PHASES = 13;
	localparam int PHASE_ITEMS = 100;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 150;
	localparam int CYCLE_LIMIT = 300000;
	localparam int REPORT_MAX = 10;
	localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

	typedef struct packed {
		logic signed [VB-1:0] x;
		logic signed [VB-1:0] y;
		logic signed [VB-1:0] z;
	} vec3_t;

	typedef struct packed {
		logic signed [VB-1:0] x;
		logic signed [VB-1:0] y;
		logic signed [VB-1:0] z;
		logic                 clip;
	} rot3_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_VEC, ROW_VEC_EXP} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  cfg_sel;
		logic [QUAT_W-1:0]     qval;
		vec3_t                 v;
		rot3_t                 r;
	} stim_row_t;

	localparam int DIR_N = 42;

	// Directed rows: identity after reset, quarter scale for rounding ties,
	// scale four for saturation, half turn about x, register extremes, a quarter
	// turn about z and a near-identity quaternion with one-lsb x and y.
	stim_row_t dir_rows [DIR_N] = '{
		'{ROW_VEC_EXP, REG_QUAT_W, '0, '{24'sd0, 24'sd0, 24'sd0},
			'{24'sd0, 24'sd0, 24'sd0, 1'b0}},
		'{ROW_VEC_EXP, REG_QUAT_W, '0, '{VMAX, VMIN, 24'sd1}, '{VMAX, VMIN, 24'sd1, 1'b0}},
		'{ROW_VEC_EXP, REG_QUAT_W, '0, '{VMIN, VMAX, -24'sd1}, '{VMIN, VMAX, -24'sd1, 1'b0}},
		'{ROW_VEC_EXP, REG_QUAT_W, '0, '{24'sh555555, 24'shAAAAAA, 24'sh0F0F0F},
			'{24'sh555555, 24'shAAAAAA, 24'sh0F0F0F, 1'b0}},
		'{ROW_CFG, REG_QUAT_W, 16'd8192, '0, '0},
		'{ROW_VEC_EXP, REG_QUAT_W, '0, '{24'sd2, -24'sd2, 24'sd6},
			'{24'sd1, 24'sd0, 24'sd2, 1'b0}},
		'{ROW_VEC_EXP, REG_QUAT_W, '0, '{-24'sd6, 24'sd1, -24'sd1},
			'{-24'sd1, 24'sd0, 24'sd0, 1'b0}},
		'{ROW_VEC_EXP, REG_QUAT_W, '0, '{VMAX, VMIN, 24'sd3},
			'{24'sd2097152, -24'sd2097152, 24'sd1, 1'b0}},
		'{ROW_CFG, REG_QUAT_W, 16'h8000, '0, '0},
		'{ROW_VEC_EXP, REG_QUAT_W, '0, '{VMAX, VMIN, 24'sd0}, '{VMAX, VMIN, 24'sd0, 1'b1}},
		'{ROW_VEC_EXP, REG_QUAT_W, '0, '{24'sd1, -24'sd1, 24'sd2097151},
			'{24'sd4, -24'sd4, 24'sd8388604, 1'b0}},
		'{ROW_VEC_EXP, REG_QUAT_W, '0, '{24'sd2097152, 24'sd0, 24'sd0},
			'{VMAX, 24'sd0, 24'sd0, 1'b1}},
		'{ROW_VEC_EXP, REG_QUAT_W, '0, '{-24'sd2097152, 24'sd0, 24'sd0},
			'{VMIN, 24'sd0, 24'sd0, 1'b0}},
		'{ROW_CFG, REG_QUAT_W, 16'd0, '0, '0},
		'{ROW_CFG, REG_QUAT_X, 16'd16384, '0, '0},
		'{ROW_VEC_EXP, REG_QUAT_W, '0, '{24'sd5, -24'sd7, 24'sd9},
			'{24'sd5, 24'sd7, -24'sd9, 1'b0}},
		'{ROW_VEC_EXP, REG_QUAT_W, '0, '{VMAX, VMIN, VMAX},
			'{VMAX, VMAX, -24'sd8388607, 1'b1}},
		'{ROW_CFG, REG_QUAT_W, 16'h7FFF, '0, '0},
		'{ROW_CFG, REG_QUAT_X, 16'h7FFF, '0, '0},
		'{ROW_CFG, REG_QUAT_Y, 16'h7FFF, '0, '0},
		'{ROW_CFG, REG_QUAT_Z, 16'h7FFF, '0, '0},
		'{ROW_VEC, REG_QUAT_W, '0, '{VMAX, VMAX, VMAX}, '0},
		'{ROW_VEC, REG_QUAT_W, '0, '{VMIN, 24'sd1, -24'sd1}, '0},
		'{ROW_VEC, REG_QUAT_W, '0, '{24'sd12345, -24'sd54321, 24'sd777}, '0},
		'{ROW_CFG, REG_QUAT_W, 16'h8000, '0, '0},
		'{ROW_CFG, REG_QUAT_X, 16'h8000, '0, '0},
		'{ROW_CFG, REG_QUAT_Y, 16'h8000, '0, '0},
		'{ROW_CFG, REG_QUAT_Z, 16'h8000, '0, '0},
		'{ROW_VEC, REG_QUAT_W, '0, '{VMAX, VMIN, VMAX}, '0},
		'{ROW_VEC, REG_QUAT_W, '0, '{-24'sd3, 24'sd2, 24'sd1}, '0},
		'{ROW_CFG, REG_QUAT_W, 16'd11585, '0, '0},
		'{ROW_CFG, REG_QUAT_X, 16'd0, '0, '0},
		'{ROW_CFG, REG_QUAT_Y, 16'd0, '0, '0},
		'{ROW_CFG, REG_QUAT_Z, 16'd11585, '0, '0},
		'{ROW_VEC, REG_QUAT_W, '0, '{24'sd1000000, 24'sd0, 24'sd0}, '0},
		'{ROW_VEC, REG_QUAT_W, '0, '{24'sd0, -24'sd1000000, 24'sd4194304}, '0},
		'{ROW_VEC, REG_QUAT_W, '0, '{VMAX, VMAX, VMIN}, '0},
		'{ROW_CFG, REG_QUAT_W, 16'd16384, '0, '0},
		'{ROW_CFG, REG_QUAT_X, 16'hFFFF, '0, '0},
		'{ROW_CFG, REG_QUAT_Y, 16'd1, '0, '0},
		'{ROW_CFG, REG_QUAT_Z, 16'd0, '0, '0},
		'{ROW_VEC, REG_QUAT_W, '0, '{VMAX, VMIN, VMAX}, '0}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [QUAT_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic signed [VB-1:0] vec_x;
	logic signed [VB-1:0] vec_y;
	logic signed [VB-1:0] vec_z;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [VB-1:0] rot_x;
	logic signed [VB-1:0] rot_y;
	logic signed [VB-1:0] rot_z;
	logic                 clipped;

	// Shadow copy of the quaternion registers and the rotations still owed.
	logic signed [QUAT_W-1:0] quat_shadow [NUM_QUAT_REGS];
	rot3_t pending_rot [$];

	bit tx_burst;
	bit rx_burst;
	int unsigned mismatches;
	int unsigned vec_count;
	int unsigned rot_count;
	int unsigned clip_count;
	int unsigned reg_writes;
	int unsigned quat_settings;
	int unsigned cycle_count;

	quaternion_vector_rotate_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.vec_x     (vec_x),
		.vec_y     (vec_y),
		.vec_z     (vec_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.rot_x     (rot_x),
		.rot_y     (rot_y),
		.rot_z     (rot_z),
		.clipped   (clipped)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Rotation matrix from the current quaternion, applied to one vector, with
	// round-half-up and saturation of each component.
	function automatic rot3_t rotate_by_quat(input vec3_t v);
		longint qw, qx, qy, qz;
		longint ww, wx, wy, wz, xx, xy, xz, yy, yz, zz;
		longint m [3][3];
		longint comp [3];
		longint acc;
		logic signed [VB-1:0] res [3];
		logic clip;
		rot3_t r;
		qw = longint'(quat_shadow[REG_QUAT_W]);
		qx = longint'(quat_shadow[REG_QUAT_X]);
		qy = longint'(quat_shadow[REG_QUAT_Y]);
		qz = longint'(quat_shadow[REG_QUAT_Z]);
		ww = qw * qw; wx = qw * qx; wy = qw * qy; wz = qw * qz;
		xx = qx * qx; xy = qx * qy; xz = qx * qz;
		yy = qy * qy; yz = qy * qz; zz = qz * qz;
		m[0][0] = ww + xx - yy - zz;
		m[0][1] = 2 * (xy - wz);
		m[0][2] = 2 * (wy + xz);
		m[1][0] = 2 * (wz + xy);
		m[1][1] = ww - xx + yy - zz;
		m[1][2] = 2 * (yz - wx);
		m[2][0] = 2 * (xz - wy);
		m[2][1] = 2 * (wx + yz);
		m[2][2] = ww - xx - yy + zz;
		comp[0] = longint'(v.x);
		comp[1] = longint'(v.y);
		comp[2] = longint'(v.z);
		clip = 1'b0;
		for (int i = 0; i < 3; i++) begin
			acc = m[i][0] * comp[0] + m[i][1] * comp[1] + m[i][2] * comp[2];
			acc = (acc + (longint'(1) <<< (2 * QF - 1))) >>> (2 * QF);
			if (acc > longint'(VMAX)) begin
				res[i] = VMAX;
				clip = 1'b1;
			end else if (acc < longint'(VMIN)) begin
				res[i] = VMIN;
				clip = 1'b1;
			end else begin
				res[i] = acc[VB-1:0];
			end
		end
		r.x = res[0];
		r.y = res[1];
		r.z = res[2];
		r.clip = clip;
		return r;
	endfunction

	// One vector component: mostly full range, some scaled down, some extremes.
	function automatic logic signed [VB-1:0] rand_comp();
		logic signed [VB-1:0] t;
		int unsigned sel;
		t = VB'($urandom);
		sel = $urandom_range(0, 3);
		if (sel == 2) begin
			t = t >>> $urandom_range(1, VB - 2);
		end else if (sel == 3) begin
			case ($urandom_range(0, 4))
				0: t = VMAX;
				1: t = VMIN;
				2: t = '0;
				3: t = VB'(1);
				default: t = '1;
			endcase
		end
		return t;
	endfunction

	// One quaternion register value: full range, near unit scale, or an extreme.
	function automatic logic [QUAT_W-1:0] rand_quat_val();
		logic [QUAT_W-1:0] q;
		case ($urandom_range(0, 2))
			0: q = QUAT_W'($urandom);
			1: q = QUAT_W'(int'($urandom_range(0, 32768)) - 16384);
			default: begin
				case ($urandom_range(0, 4))
					0: q = 16'h8000;
					1: q = 16'h7FFF;
					2: q = 16'h0000;
					3: q = 16'h4000;
					default: q = 16'hC000;
				endcase
			end
		endcase
		return q;
	endfunction

	// Register write transaction; called and left at a falling edge.
	task automatic write_quat_reg(input logic [CFG_IDX_W-1:0] sel,
			input logic [QUAT_W-1:0] val);
		cfg_index <= sel;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		quat_shadow[sel] = val;
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one vector after a random gap, or none while tx_burst is set, and record the rotation it is owed.
	task automatic offer_vec(input vec3_t v, input rot3_t want);
		int unsigned gap;
		gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		vec_x <= v.x;
		vec_y <= v.y;
		vec_z <= v.z;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_rot.push_back(want);
		vec_count++;
		@(negedge clk);
	endtask

	// Stop offering, wait for every owed result, then let the pipeline settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_rot.size() != 0) @(negedge clk);
		repeat (IDLE_PAD) @(negedge clk);
	endtask

	// Stimulus: directed table first, then random phases under fresh quaternions.
	initial begin : stimulus
		stim_row_t row;
		vec3_t v;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		vec_x = '0;
		vec_y = '0;
		vec_z = '0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		quat_shadow[REG_QUAT_W] = 16'sd16384;
		quat_shadow[REG_QUAT_X] = '0;
		quat_shadow[REG_QUAT_Y] = '0;
		quat_shadow[REG_QUAT_Z] = '0;
		quat_settings = 1;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			row = dir_rows[i];
			case (row.kind)
				ROW_CFG: begin
					wait_idle();
					write_quat_reg(row.cfg_sel, row.qval);
				end
				ROW_VEC: offer_vec(row.v, rotate_by_quat(row.v));
				default: offer_vec(row.v, row.r);
			endcase
		end
		quat_settings += 7;

		for (int p = 0; p < RAND_PHASES; p++) begin
			wait_idle();
			for (int k = 0; k < NUM_QUAT_REGS; k++) begin
				if ($urandom_range(0, 3) != 0)
					write_quat_reg(CFG_IDX_W'(k), rand_quat_val());
			end
			quat_settings++;
			// Every fourth phase runs both sides flat out.
			tx_burst = (p % 4 == 2);
			rx_burst = (p % 4 == 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				v.x = rand_comp();
				v.y = rand_comp();
				v.z = rand_comp();
				offer_vec(v, rotate_by_quat(v));
			end
		end
		wait_idle();

		$display("Rotated %0d vectors under %0d quaternion settings (%0d register writes).",
			vec_count, quat_settings, reg_writes);
		$display("%0d results saturated; receiver held off %0d cycles once; %0d mismatches.",
			clip_count, HOLD_CYCLES, mismatches);
		if (mismatches == 0) begin
			$display("tb_quaternion_vector_rotate_unit: PASS");
		end else begin
			$display("tb_quaternion_vector_rotate_unit: FAIL");
		end
		$finish;
	end

	// Receiver: random stalls per result, and one long hold-off to fill the pipeline.
	initial begin : sink_side
		int unsigned gap;
		int unsigned taken;
		taken = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken == HOLD_AT)
				gap = HOLD_CYCLES;
			else
				gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			taken++;
			@(negedge clk);
		end
	end

	// Compare each result transaction with the oldest owed rotation.
	always @(posedge clk) begin : check_rot
		rot3_t want;
		if (arst_n && out_valid && !out_stall) begin
			rot_count++;
			if (clipped)
				clip_count++;
			if (pending_rot.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: result with no vector outstanding: (%0d, %0d, %0d) clipped %0b",
						$time, rot_x, rot_y, rot_z, clipped);
			end else begin
				want = pending_rot.pop_front();
				if (rot_x !== want.x || rot_y !== want.y || rot_z !== want.z ||
						clipped !== want.clip) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: rotation %0d expected (%0d, %0d, %0d) clipped %0b, got (%0d, %0d, %0d) clipped %0b",
							$time, rot_count, want.x, want.y, want.z, want.clip,
							rot_x, rot_y, rot_z, clipped);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, pending_rot.size());
			$display("tb_quaternion_vector_rotate_unit: FAIL");
			$finish;
		end
	end

endmodule
